### design/dtt_pkg.sv
package dtt_pkg;

	localparam int SLOTS_DEFAULT = 256;
	localparam int TIME_W = 48;
	localparam int DUR_W = 32;
	localparam int ID_W = 8;

	typedef enum logic [1:0] {
		FUNC_START   = 2'd0,
		FUNC_STOP    = 2'd1,
		FUNC_RESTART = 2'd2,
		FUNC_TICK    = 2'd3
	} func_t;

	typedef struct packed {
		logic [1:0]       func;
		logic [ID_W-1:0]  timer_slot;
		logic [DUR_W-1:0] duration;
	} in_item_t;

	typedef struct packed {
		logic            status;
		logic [ID_W-1:0] slot_out;
		logic            expired;
		logic [ID_W-1:0] expired_slot;
	} out_item_t;

endpackage

### design/dtt_ram.sv
module dtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/deadline_timer_table.sv
// Channel | Direction | Handshake       | Payload
// in      | input     | in_valid/ready  | dtt_pkg::in_item_t (func, timer_slot, duration)
// out     | output    | out_valid/ready | dtt_pkg::out_item_t (status, slot_out, expired, ...)
//
// One item at a time, through one entry memory with a registered read port.
// Start probes up to SLOTS slots in the free-slot search, reads up to SLOTS list
// entries while finding its place, then writes in S_INS_WN, S_INS_WP and S_INS_WS.
// Stop reads and unlinks the entry, restart adds an insert, tick reads the head entry.
// After reset a clearing pass zeroes all SLOTS entries of the memory before the first item.
// The result sits in an output register; the next item is taken after its transfer.
module deadline_timer_table #(
	parameter int SLOTS = dtt_pkg::SLOTS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  dtt_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output dtt_pkg::out_item_t out_data
);

	localparam int AW = $clog2(SLOTS);
	// Entry: active, next_ok, next, prev, interval, deadline.
	localparam int EW = 2 + 2 * AW + dtt_pkg::DUR_W + dtt_pkg::TIME_W;

	typedef struct packed {
		logic                       active;
		logic                       nok;
		logic [AW-1:0]              nxt;
		logic [AW-1:0]              prv;
		logic [dtt_pkg::DUR_W-1:0]  ivl;
		logic [dtt_pkg::TIME_W-1:0] dl;
	} entry_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_SRCH_RD, S_SRCH_CHK, S_INS_RD, S_INS_CHK,
		S_INS_WN, S_INS_WP, S_INS_WS, S_RM_RD, S_RM_CHK, S_RM_NRD, S_RM_NCHK,
		S_RM_PRD, S_RM_PCHK, S_RM_END, S_TICK_RD, S_TICK_CHK, S_OUT
	} state_t;

	state_t state_q;
	logic we;
	logic [AW-1:0] waddr, raddr;
	entry_t wdata, rdata;
	logic [EW-1:0] rraw;

	dtt_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rraw)
	);
	assign rdata = entry_t'(rraw);

	logic [AW-1:0] head_q, search_q, cnt_q, s_q, cur_q, p_q, n_q, snxt_q;
	logic [AW:0] steps_q;
	logic empty_q, armed_q, p_ok_q, nv_q, restart_q, head_rm_q, snok_q;
	logic [dtt_pkg::TIME_W-1:0] now_q, dl_q;
	logic [dtt_pkg::DUR_W-1:0] ivl_q;
	entry_t pent_q, nent_q;
	dtt_pkg::in_item_t item_q;
	dtt_pkg::out_item_t res_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data = res_q;

	// Combinational memory access, chosen by state.
	always_comb begin
		we = 1'b0;
		waddr = s_q;
		wdata = '0;
		raddr = cur_q;
		unique case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				waddr = cnt_q;
			end
			S_SRCH_RD, S_INS_RD, S_TICK_RD: raddr = cur_q;
			S_RM_RD: raddr = s_q;
			S_RM_NRD: raddr = n_q;
			S_RM_PRD: raddr = p_q;
			S_RM_NCHK: begin
				// The successor of a removed inner entry gets its prev pointer patched.
				if (!head_rm_q) begin
					we = 1'b1;
					waddr = n_q;
					wdata = rdata;
					wdata.prv = p_q;
				end
			end
			S_RM_PCHK: begin
				we = 1'b1;
				waddr = p_q;
				wdata = rdata;
				wdata.nok = nv_q;
				wdata.nxt = n_q;
			end
			S_RM_END: begin
				if (!restart_q) begin
					we = 1'b1;
					waddr = s_q;
				end
			end
			S_INS_WN: begin
				we = 1'b1;
				waddr = n_q;
				wdata = nent_q;
				wdata.prv = s_q;
			end
			S_INS_WP: begin
				if (p_ok_q) begin
					we = 1'b1;
					waddr = p_q;
					wdata = pent_q;
					wdata.nok = 1'b1;
					wdata.nxt = s_q;
				end
			end
			S_INS_WS: begin
				we = 1'b1;
				waddr = s_q;
				wdata = '{active: 1'b1, nok: snok_q, nxt: snxt_q,
					prv: (p_ok_q ? p_q : '0), ivl: ivl_q, dl: dl_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q <= '0;
			head_q <= '0;
			search_q <= '0;
			empty_q <= 1'b1;
			armed_q <= 1'b0;
			now_q <= '0;
			s_q <= '0;
			cur_q <= '0;
			p_q <= '0;
			n_q <= '0;
			snxt_q <= '0;
			snok_q <= 1'b0;
			steps_q <= '0;
			p_ok_q <= 1'b0;
			nv_q <= 1'b0;
			restart_q <= 1'b0;
			head_rm_q <= 1'b0;
			dl_q <= '0;
			ivl_q <= '0;
			pent_q <= '0;
			nent_q <= '0;
			item_q <= '0;
			res_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == AW'(SLOTS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (in_valid) begin
					item_q <= in_data;
					restart_q <= (in_data.func == dtt_pkg::FUNC_RESTART);
					steps_q <= '0;
					unique case (dtt_pkg::func_t'(in_data.func))
						dtt_pkg::FUNC_START: begin
							res_q <= '{status: 1'b1, slot_out: '0, expired: 1'b0,
								expired_slot: '0};
							cur_q <= search_q;
							state_q <= (in_data.duration != '0) ? S_SRCH_RD : S_OUT;
						end
						dtt_pkg::FUNC_STOP, dtt_pkg::FUNC_RESTART: begin
							res_q <= '{status: 1'b1, slot_out: in_data.timer_slot,
								expired: 1'b0, expired_slot: '0};
							s_q <= AW'(in_data.timer_slot);
							state_q <= (32'(in_data.timer_slot) < 32'(SLOTS)) ? S_RM_RD : S_OUT;
						end
						default: begin
							res_q <= '0;
							now_q <= now_q + 1'b1;
							cur_q <= head_q;
							state_q <= S_TICK_RD;
						end
					endcase
				end
				S_SRCH_RD: state_q <= S_SRCH_CHK;
				S_SRCH_CHK: begin
					if (!rdata.active) begin
						s_q <= cur_q;
						search_q <= (cur_q == AW'(SLOTS - 1)) ? '0 : cur_q + 1'b1;
						ivl_q <= item_q.duration;
						dl_q <= now_q + dtt_pkg::TIME_W'(item_q.duration);
						res_q <= '{status: 1'b0, slot_out: dtt_pkg::ID_W'(cur_q),
							expired: 1'b0, expired_slot: '0};
						cur_q <= head_q;
						p_ok_q <= 1'b0;
						snok_q <= 1'b0;
						snxt_q <= '0;
						state_q <= empty_q ? S_INS_WP : S_INS_RD;
					end else if (steps_q == (AW+1)'(SLOTS - 1)) begin
						state_q <= S_OUT;
					end else begin
						steps_q <= steps_q + 1'b1;
						cur_q <= (cur_q == AW'(SLOTS - 1)) ? '0 : cur_q + 1'b1;
						state_q <= S_SRCH_RD;
					end
				end
				S_INS_RD: state_q <= S_INS_CHK;
				S_INS_CHK: begin
					// Equal deadlines are passed so that insertion order is kept.
					if (rdata.dl <= dl_q) begin
						p_q <= cur_q;
						p_ok_q <= 1'b1;
						pent_q <= rdata;
						if (rdata.nok) begin
							cur_q <= rdata.nxt;
							state_q <= S_INS_RD;
						end else begin
							state_q <= S_INS_WP;
						end
					end else begin
						snok_q <= 1'b1;
						snxt_q <= cur_q;
						n_q <= cur_q;
						nent_q <= rdata;
						state_q <= S_INS_WN;
					end
				end
				S_INS_WN: state_q <= S_INS_WP;
				S_INS_WP: begin
					if (!p_ok_q) begin
						head_q <= s_q;
						empty_q <= 1'b0;
						armed_q <= 1'b1;
					end
					state_q <= S_INS_WS;
				end
				S_INS_WS: state_q <= S_OUT;
				S_RM_RD: state_q <= S_RM_CHK;
				S_RM_CHK: begin
					if (!rdata.active) begin
						state_q <= S_OUT;
					end else begin
						res_q <= '{status: 1'b0, slot_out: item_q.timer_slot,
							expired: 1'b0, expired_slot: '0};
						ivl_q <= rdata.ivl;
						nv_q <= rdata.nok;
						n_q <= rdata.nxt;
						p_q <= rdata.prv;
						head_rm_q <= (!empty_q && s_q == head_q);
						if (rdata.nok) begin
							state_q <= S_RM_NRD;
						end else if (!empty_q && s_q == head_q) begin
							empty_q <= 1'b1;
							head_q <= '0;
							armed_q <= 1'b0;
							state_q <= S_RM_END;
						end else begin
							state_q <= S_RM_PRD;
						end
					end
				end
				S_RM_NRD: state_q <= S_RM_NCHK;
				S_RM_NCHK: begin
					if (head_rm_q) begin
						// A new head that is already due fires right away.
						head_q <= n_q;
						if (rdata.dl <= now_q) begin
							res_q <= '{status: 1'b0, slot_out: item_q.timer_slot,
								expired: 1'b1, expired_slot: dtt_pkg::ID_W'(n_q)};
							armed_q <= 1'b0;
						end else begin
							armed_q <= 1'b1;
						end
						state_q <= S_RM_END;
					end else begin
						state_q <= S_RM_PRD;
					end
				end
				S_RM_PRD: state_q <= S_RM_PCHK;
				S_RM_PCHK: state_q <= S_RM_END;
				S_RM_END: begin
					if (restart_q) begin
						dl_q <= now_q + dtt_pkg::TIME_W'(ivl_q);
						cur_q <= head_q;
						p_ok_q <= 1'b0;
						snok_q <= 1'b0;
						snxt_q <= '0;
						state_q <= empty_q ? S_INS_WP : S_INS_RD;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_TICK_RD: state_q <= S_TICK_CHK;
				S_TICK_CHK: begin
					if (armed_q && !empty_q && rdata.dl == now_q) begin
						res_q <= '{status: 1'b0, slot_out: '0, expired: 1'b1,
							expired_slot: dtt_pkg::ID_W'(head_q)};
						armed_q <= 1'b0;
					end
					state_q <= S_OUT;
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
